// ===== hdl/b32e_pkg.sv =====
// base32 encoder package: group record, alphabet and padding helpers
// used by the front, queue and back of the encoder; no dependencies
package b32e_pkg;

    localparam int GROUP_BYTES = 5;
    localparam int GROUP_CHARS = 8;
    localparam int GROUP_BITS  = 8 * GROUP_BYTES;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] PAD_CHAR  = 8'h3D;
    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [7:0] CHAR_TWO  = 8'h32;
    localparam logic [4:0] ALPHA_LEN = 5'd26;

    typedef struct packed {
        logic [GROUP_BITS-1:0] bits;
        logic [3:0]            keep;
        logic                  last;
    } t_group;

    function automatic logic [7:0] sym_to_ascii(input logic [4:0] v);
        logic [7:0] c;
        if (v < ALPHA_LEN) begin
            c = CHAR_A + {3'b000, v};
        end else begin
            c = CHAR_TWO + {3'b000, v - ALPHA_LEN};
        end
        return c;
    endfunction

    function automatic logic [3:0] keep_for(input logic [2:0] have);
        logic [3:0] k;
        case (have)
            3'd1:    k = 4'd2;
            3'd2:    k = 4'd4;
            3'd3:    k = 4'd5;
            3'd4:    k = 4'd7;
            3'd5:    k = 4'd8;
            default: k = 4'd0;
        endcase
        return k;
    endfunction

endpackage

// ===== hdl/b32e_front.sv =====
// front end: gathers bytes into 40-bit groups and pushes finished groups
// depends on b32e_pkg
module b32e_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_final_byte,
    input  logic               i_q_full,
    output logic               o_push,
    output b32e_pkg::t_group   o_group
);

    logic [31:0] r_pending;
    logic [31:0] n_pending;
    logic [2:0]  r_count;
    logic [2:0]  n_count;
    logic [2:0]  have;
    logic        accept;
    logic        done;
    logic [39:0] full;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign have    = (r_count > 3'd4) ? 3'd5 : r_count + 3'd1;
    assign done    = (have == 3'd5) || i_final_byte;
    assign full    = {r_pending, i_data_byte};
    assign o_push  = accept && done;

    always_comb begin
        case (have)
            3'd1:    o_group.bits = full << 32;
            3'd2:    o_group.bits = full << 24;
            3'd3:    o_group.bits = full << 16;
            3'd4:    o_group.bits = full << 8;
            default: o_group.bits = full;
        endcase
        o_group.keep = b32e_pkg::keep_for(have);
        o_group.last = i_final_byte;
        n_pending = r_pending;
        n_count   = r_count;
        if (accept) begin
            if (done) begin
                n_pending = '0;
                n_count   = '0;
            end else begin
                n_pending = {r_pending[23:0], i_data_byte};
                n_count   = have;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_count   <= '0;
        end else begin
            r_pending <= n_pending;
            r_count   <= n_count;
        end
    end

endmodule

// ===== hdl/b32e_queue.sv =====
// short queue of finished groups between front and back
// depends on b32e_pkg
module b32e_queue #(
    parameter int DEPTH = b32e_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  b32e_pkg::t_group  i_group,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output b32e_pkg::t_group  o_group
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    b32e_pkg::t_group r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_group = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// ===== hdl/b32e_back.sv =====
// back end: turns each queued group into eight characters, one per beat
// depends on b32e_pkg
module b32e_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  b32e_pkg::t_group  i_group,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_out_char,
    output logic              o_final_char
);

    logic [39:0] r_bits;
    logic [3:0]  r_keep;
    logic        r_last;
    logic        r_busy;
    logic [2:0]  r_k;
    logic        r_valid;
    logic [7:0]  r_char;
    logic        r_fin;

    logic        adv;
    logic [39:0] src_bits;
    logic [3:0]  src_keep;
    logic        src_last;
    logic        go;

    assign adv      = !r_valid || !i_stall;
    assign src_bits = r_busy ? r_bits : i_group.bits;
    assign src_keep = r_busy ? r_keep : i_group.keep;
    assign src_last = r_busy ? r_last : i_group.last;
    assign go       = adv && (r_busy || i_q_valid);
    assign o_pop    = adv && !r_busy && i_q_valid;

    assign o_valid      = r_valid;
    assign o_out_char   = r_char;
    assign o_final_char = r_fin;

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_bits <= src_bits << 5;
            r_keep <= src_keep;
            r_last <= src_last;
            r_char <= ({1'b0, r_k} < src_keep) ?
                      b32e_pkg::sym_to_ascii(src_bits[39:35]) : b32e_pkg::PAD_CHAR;
            r_fin  <= src_last && (r_k == 3'd7);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_k     <= '0;
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= go;
            if (go) begin
                r_k    <= r_k + 3'd1;
                r_busy <= (r_k != 3'd7);
            end
        end
    end

endmodule

// ===== hdl/base32_encoder.sv =====
// base32 encoder top level: front, group queue and character back end
// depends on b32e_pkg, b32e_front, b32e_queue, b32e_back
//
// Takes one message byte per beat and emits the base32 text one character
// per beat, eight characters for every group of five bytes, padded with '='
// when the byte marked final leaves a short group; o_final_char marks the
// last character. The front takes a byte every cycle while the group queue
// has room; the back drives one character per cycle while the receiver does
// not stall, so sustained input is set by the output channel. A finished
// group waits in the group queue, and its characters leave from a register.
module base32_encoder #(
    parameter int QUEUE_DEPTH = b32e_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_char,
    output logic       o_final_char
);

    logic             q_full;
    logic             q_push;
    logic             q_pop;
    logic             q_valid;
    b32e_pkg::t_group g_in;
    b32e_pkg::t_group g_out;

    b32e_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_group      (g_in)
    );

    b32e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_group (g_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_group (g_out)
    );

    b32e_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_group      (g_out),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_char   (o_out_char),
        .o_final_char (o_final_char)
    );

endmodule

// ===== test/base32_encoder_chk.sv =====
`timescale 1ns / 1ps
// checker for base32_encoder: watches both channels, predicts the character stream
// from accepted bytes and compares every accepted character; depends on b32e_pkg
module base32_encoder_chk (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_byte,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_out_char,
    input  logic       i_final_char,
    output int         o_errors,
    output int         o_waiting,
    output int         o_in_beats,
    output int         o_out_beats,
    output int         o_messages
);

    localparam logic [7:0] ASC_UPPER_A = 8'h41;
    localparam logic [7:0] ASC_DIGIT_2 = 8'h32;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } t_b32_char;

    t_b32_char   text_q[$];
    logic [31:0] held_bytes = '0;
    int          held_n = 0;

    function automatic logic [7:0] symbol_char(input logic [4:0] sym);
        if (sym < 5'd26) begin
            return ASC_UPPER_A + {3'b000, sym};
        end
        return ASC_DIGIT_2 + {3'b000, sym - 5'd26};
    endfunction

    // gathers one byte, and on a full or final group queues its eight characters
    function automatic void encode_byte(input logic [7:0] b, input logic fin);
        logic [39:0] grp;
        logic [4:0]  sym;
        t_b32_char   c;
        int          have;
        int          keep;
        have = held_n + 1;
        if (have < b32e_pkg::GROUP_BYTES && !fin) begin
            held_bytes = {held_bytes[23:0], b};
            held_n = have;
            return;
        end
        grp = {held_bytes, b};
        grp = grp << (8 * (b32e_pkg::GROUP_BYTES - have));
        keep = (8 * have + 4) / 5;
        for (int k = 0; k < b32e_pkg::GROUP_CHARS; k++) begin
            sym = grp[39 - 5 * k -: 5];
            c.ch = (k < keep) ? symbol_char(sym) : b32e_pkg::PAD_CHAR;
            c.fin = fin && (k == b32e_pkg::GROUP_CHARS - 1);
            text_q.insert(text_q.size(), c);
        end
        held_bytes = '0;
        held_n = 0;
    endfunction

    always @(posedge i_clk) begin
        t_b32_char want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                encode_byte(i_data_byte, i_final_byte);
                o_in_beats++;
            end
            if (i_out_valid && !i_out_stall) begin
                o_out_beats++;
                if (i_final_char) begin
                    o_messages++;
                end
                if (text_q.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected char beat %h final %b",
                             $time, i_out_char, i_final_char);
                end else begin
                    want = text_q.pop_front();
                    if (i_out_char !== want.ch) begin
                        o_errors++;
                        $display("%0t: out_char expected %h actual %h",
                                 $time, want.ch, i_out_char);
                    end
                    if (i_final_char !== want.fin) begin
                        o_errors++;
                        $display("%0t: final_char expected %b actual %b",
                                 $time, want.fin, i_final_char);
                    end
                end
            end
        end else begin
            o_errors    = 0;
            o_in_beats  = 0;
            o_out_beats = 0;
            o_messages  = 0;
            held_bytes  = '0;
            held_n      = 0;
            text_q.delete();
        end
        o_waiting = text_q.size();
    end

endmodule

// ===== test/base32_encoder_tb.sv =====
`timescale 1ns / 1ps
// testbench top for base32_encoder: drives byte messages with bursty timing and
// a stalling receiver; depends on base32_encoder and base32_encoder_chk
module base32_encoder_tb;

    localparam int ITEM_TARGET = 330;
    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 200;

    typedef enum int {FILL_ZERO, FILL_ONES, FILL_RANDOM} t_fill;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       in_final = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_char;
    logic       out_final;

    int errors;
    int waiting;
    int in_beats;
    int out_beats;
    int messages;
    int bytes_sent = 0;
    int burst_left = 0;
    int idle_cycles = 0;
    bit held_off = 1'b0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    base32_encoder uut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (in_valid),
        .o_stall      (in_stall),
        .i_data_byte  (in_byte),
        .i_final_byte (in_final),
        .o_valid      (out_valid),
        .i_stall      (out_stall),
        .o_out_char   (out_char),
        .o_final_char (out_final)
    );

    base32_encoder_chk chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_data_byte  (in_byte),
        .i_final_byte (in_final),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_char   (out_char),
        .i_final_char (out_final),
        .o_errors     (errors),
        .o_waiting    (waiting),
        .o_in_beats   (in_beats),
        .o_out_beats  (out_beats),
        .o_messages   (messages)
    );

    // watchdog on cycles where neither channel moves a beat
    always @(posedge clk) begin
        if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) begin
            idle_cycles = 0;
        end else if (rst_n) begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("base32_encoder_tb: errors");
                $finish;
            end
        end
    end

    // receiver stall pattern, with one long hold-off once traffic is flowing
    initial begin
        int span;
        int mode;
        forever begin
            span = $urandom_range(10, 60);
            mode = $urandom_range(0, 2);
            repeat (span) begin
                @(negedge clk);
                if (!held_off && in_beats >= 40) begin
                    held_off = 1'b1;
                    out_stall = 1'b1;
                    repeat (HOLD_CYCLES) @(negedge clk);
                end
                case (mode)
                    0: out_stall = 1'b0;
                    1: out_stall = ($urandom_range(0, 3) == 0);
                    default: out_stall = ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
        end
        in_valid = 1'b1;
        in_byte = b;
        in_final = fin;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_message(input int len, input t_fill fill);
        logic [7:0] b;
        for (int n = 0; n < len; n++) begin
            case (fill)
                FILL_ZERO: b = 8'h00;
                FILL_ONES: b = 8'hFF;
                default:   b = 8'($urandom_range(0, 255));
            endcase
            send_byte(b, n == len - 1);
        end
    endtask

    initial begin
        int len;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // every partial group length, a full final group, and a group that runs on
        send_message(1, FILL_ZERO);
        send_message(2, FILL_ONES);
        send_message(3, FILL_ZERO);
        send_message(4, FILL_ONES);
        send_message(5, FILL_ONES);
        send_message(6, FILL_RANDOM);

        while (bytes_sent < ITEM_TARGET) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 23)
                                               : $urandom_range(1, 10);
            send_message(len, FILL_RANDOM);
        end
        in_valid = 1'b0;

        wait (waiting == 0);
        repeat (10) @(posedge clk);

        $display("run covered %0d bytes in %0d messages, %0d characters checked",
                 in_beats, messages, out_beats);
        $display("all short-group paddings and a %0d-cycle output hold-off included",
                 HOLD_CYCLES);
        if (errors == 0) begin
            $display("base32_encoder_tb: clean");
        end else begin
            $display("base32_encoder_tb: errors");
        end
        $finish;
    end

endmodule
